@@ design/murmur3_32bit_stream_hash_unit_macros.svh @@
// assertion macros of the murmur3 stream hash unit, included by the queue
`ifndef MURMUR3_32BIT_STREAM_HASH_UNIT_MACROS_SVH
`define MURMUR3_32BIT_STREAM_HASH_UNIT_MACROS_SVH

// condition must never hold while out of reset
`define MMH_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error(msg);

// antecedent implies consequent on the next clock
`define MMH_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/mmh_pkg.sv @@
// shared constants, types and functions of the murmur3 stream hash unit
package mmh_pkg;

  localparam logic [31:0] MixC1   = 32'hcc9e2d51;
  localparam logic [31:0] MixC2   = 32'h1b873593;
  localparam logic [31:0] MixAdd  = 32'he6546b64;
  localparam logic [31:0] FinC1   = 32'h85ebca6b;
  localparam logic [31:0] FinC2   = 32'hc2b2ae35;
  localparam int unsigned KeyRot  = 15;
  localparam int unsigned HashRot = 13;

  localparam logic [2:0] FullCount  = 3'd4;
  localparam logic [2:0] EmptyCount = 3'd0;

  localparam int unsigned QueueDepthDef = 4;

  // one classified item travelling from front to back
  typedef struct packed {
    logic [31:0] key;
    logic [2:0]  count;
    logic        last;
  } mmh_item_t;

  // queue status seen by both sides
  typedef struct packed {
    logic empty;
    logic full;
  } mmh_qstat_t;

  function automatic logic [31:0] rotl32(input logic [31:0] v, input int unsigned r);
    rotl32 = (v << r) | (v >> (32 - r));
  endfunction

  // keep only the valid low bytes of a word
  function automatic logic [31:0] byte_mask(input logic [2:0] count);
    logic [31:0] m;
    unique case (count)
      3'd0:    m = 32'h0000_0000;
      3'd1:    m = 32'h0000_00ff;
      3'd2:    m = 32'h0000_ffff;
      3'd3:    m = 32'h00ff_ffff;
      default: m = 32'hffff_ffff;
    endcase
    byte_mask = m;
  endfunction

endpackage

@@ design/mmh_front.sv @@
// front end: accepts words, normalizes the byte count and runs the key premix
module mmh_front
  import mmh_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [31:0] data_word_i,
  input  logic [2:0]  byte_count_i,
  input  logic        last_i,
  input  mmh_qstat_t  qstat_i,
  output logic        push_o,
  output mmh_item_t   item_o
);

  logic        s1_valid_q, s1_valid_d;
  logic [31:0] prod_q;
  logic [2:0]  count_q;
  logic        last_q;
  logic        accept;
  logic [2:0]  count_n;
  logic [31:0] masked;

  assign in_stall_o = s1_valid_q && qstat_i.full;
  assign accept     = in_valid_i && !in_stall_o;
  assign push_o     = s1_valid_q && !qstat_i.full;

  // non-final items and out-of-range counts are full words
  assign count_n = (!last_i || byte_count_i > FullCount) ? FullCount : byte_count_i;
  assign masked  = data_word_i & byte_mask(count_n);

  assign s1_valid_d = accept || (s1_valid_q && !push_o);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      prod_q  <= masked * MixC1;
      count_q <= count_n;
      last_q  <= last_i;
    end
  end

  assign item_o.key   = rotl32(prod_q, KeyRot) * MixC2;
  assign item_o.count = count_q;
  assign item_o.last  = last_q;

endmodule

@@ design/mmh_queue.sv @@
// small register queue between front and back
module mmh_queue
  import mmh_pkg::*;
#(
  parameter int unsigned Depth = QueueDepthDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  mmh_item_t  item_i,
  input  logic       pop_i,
  output mmh_item_t  head_o,
  output mmh_qstat_t qstat_o
);

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);

  mmh_item_t         mem_q [Depth];
  logic [PtrW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]   cnt_q, cnt_d;

  assign qstat_o.empty = (cnt_q == '0);
  assign qstat_o.full  = (cnt_q == CntW'(Depth));
  assign head_o        = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

`include "murmur3_32bit_stream_hash_unit_macros.svh"

  `MMH_ASSERT_NEVER(a_no_push_full, push_i && qstat_o.full, "queue written while full")
  `MMH_ASSERT_NEVER(a_no_pop_empty, pop_i && qstat_o.empty, "queue read while empty")
  `MMH_ASSERT_NEXT(a_push_fills, push_i && qstat_o.empty, !qstat_o.empty, "push into empty queue lost")

endmodule

@@ design/mmh_back.sv @@
// back end: running hash and byte total, finalizer pipeline and result register
module mmh_back
  import mmh_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [31:0] seed_i,
  input  mmh_item_t   head_i,
  input  mmh_qstat_t  qstat_i,
  output logic        pop_o,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] hash_value_o
);

  logic        open_q;
  logic [31:0] hash_q, total_q;
  logic [31:0] base_h, base_t, mixed, rot, hash_n, total_n;

  logic        f1_v_q, f2_v_q, f3_v_q, out_v_q;
  logic [31:0] f1_q, f2_q, f3_q, out_q;
  logic        out_rdy, f3_rdy, f2_rdy, f1_rdy;

  assign out_rdy = !out_v_q || !out_stall_i;
  assign f3_rdy  = !f3_v_q || out_rdy;
  assign f2_rdy  = !f2_v_q || f3_rdy;
  assign f1_rdy  = !f1_v_q || f2_rdy;

  // a last item needs room in the finalizer, others drain freely
  assign pop_o = !qstat_i.empty && (!head_i.last || f1_rdy);

  assign base_h  = open_q ? hash_q : seed_i;
  assign base_t  = open_q ? total_q : '0;
  assign mixed   = base_h ^ head_i.key;
  assign rot     = rotl32(mixed, HashRot);
  assign hash_n  = (head_i.count == FullCount) ? (rot << 2) + rot + MixAdd : mixed;
  assign total_n = base_t + {29'd0, head_i.count};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q  <= 1'b0;
      hash_q  <= '0;
      total_q <= '0;
      f1_v_q  <= 1'b0;
      f2_v_q  <= 1'b0;
      f3_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (pop_o) begin
        open_q  <= !head_i.last;
        hash_q  <= hash_n;
        total_q <= total_n;
      end
      if (f1_rdy)  f1_v_q  <= pop_o && head_i.last;
      if (f2_rdy)  f2_v_q  <= f1_v_q;
      if (f3_rdy)  f3_v_q  <= f2_v_q;
      if (out_rdy) out_v_q <= f3_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (f1_rdy)  f1_q  <= hash_n ^ total_n;
    if (f2_rdy)  f2_q  <= (f1_q ^ (f1_q >> 16)) * FinC1;
    if (f3_rdy)  f3_q  <= (f2_q ^ (f2_q >> 13)) * FinC2;
    if (out_rdy) out_q <= f3_q ^ (f3_q >> 16);
  end

  assign out_valid_o  = out_v_q;
  assign hash_value_o = out_q;

endmodule

@@ design/murmur3_32bit_stream_hash_unit.sv @@
// top level of the streaming murmur3 x86 32-bit hash unit
// usage:
//   input channel carries one little-endian word per transaction with its
//   valid byte count and a last-of-message flag; in_stall_o holds it off
//   output channel gives one hash_value_o transaction per message, on the
//   transaction that carries last; out_stall_i from the receiver holds it
//   seed port is a plain write channel, always ready; the seed is sampled
//   when the first word of a message reaches the back end
// throughput: one word per cycle while in_stall_o is low, set by the back end's
//   combinational hash update (xor; for full words also rotate, times five plus constant)
// a stalled result sits in the output register; middle words keep draining
//   into the running hash, and the input stalls once QueueDepth + 4 further
//   last words wait in the front, queue and finalizer
// reset clears all valid flags, the queue and the seed; no message is open
module murmur3_32bit_stream_hash_unit
  import mmh_pkg::*;
#(
  parameter int unsigned QueueDepth = QueueDepthDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // seed write channel
  input  logic        seed_valid_i,
  output logic        seed_ready_o,
  input  logic [31:0] seed_i,
  // word input channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [31:0] data_word_i,
  input  logic [2:0]  byte_count_i,
  input  logic        last_i,
  // hash output channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] hash_value_o
);

  logic [31:0] seed_q;
  logic        push, pop;
  mmh_item_t   push_item, head_item;
  mmh_qstat_t  qstat;

  // seed register, written any cycle
  assign seed_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q <= '0;
    end else if (seed_valid_i && seed_ready_o) begin
      seed_q <= seed_i;
    end
  end

  // front: normalize count, mask tail bytes, key premix over two multiplies
  mmh_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .data_word_i  (data_word_i),
    .byte_count_i (byte_count_i),
    .last_i       (last_i),
    .qstat_i      (qstat),
    .push_o       (push),
    .item_o       (push_item)
  );

  // queue decouples premix from the stateful hash update
  mmh_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (push_item),
    .pop_i   (pop),
    .head_o  (head_item),
    .qstat_o (qstat)
  );

  // back: hash update, length xor, finalizer stages, result register
  mmh_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .seed_i       (seed_q),
    .head_i       (head_item),
    .qstat_i      (qstat),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .hash_value_o (hash_value_o)
  );

endmodule
